>>> src/dse_pkg.sv
// Shared types for the descriptive statistics engine.
// Holds the command and status structs between controller and datapath.
// No dependencies.
package dse_pkg;

   typedef struct packed {
      logic load;      // store the accepted item
      logic start;     // open the scan and start the divider
      logic fetch;     // read the current candidate
      logic scan;      // read one compare operand
      logic eval;      // fold candidate counts into median and mode
      logic publish;   // load the result register and clear the set
   } dse_cmd_type;

   typedef struct packed {
      logic scan_last; // last compare operand is being read
      logic eval_last; // last candidate is being evaluated
      logic div_busy;  // mean divider still iterating
      logic out_free;  // result register can take a new result
   } dse_stat_type;

endpackage

>>> src/dse_ctrl.sv
// Controller for the descriptive statistics engine.
// Sequences load, candidate scan, division wait and result publish.
// Depends on dse_pkg.
module dse_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tlast,
   output logic                 req_tready,
   input  dse_pkg::dse_stat_type stat,
   output dse_pkg::dse_cmd_type  cmd
);

   typedef enum logic [7:0] {
      ST_LOAD  = 8'b0000_0001,
      ST_START = 8'b0000_0010,
      ST_FETCH = 8'b0000_0100,
      ST_SCAN  = 8'b0000_1000,
      ST_DRAIN = 8'b0001_0000,
      ST_EVAL  = 8'b0010_0000,
      ST_DIVW  = 8'b0100_0000,
      ST_PUB   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_LOAD);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.load = req_tvalid;
            if (req_tvalid && req_tlast) state_in = ST_START;
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = stat.eval_last ? ST_DIVW : ST_FETCH;
         end
         ST_DIVW: begin
            if (!stat.div_busy) state_in = ST_PUB;
         end
         ST_PUB: begin
            if (stat.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_LOAD;
      else       state_ff <= state_in;
   end

endmodule

>>> src/dse_div.sv
// Iterative signed divider for the mean: one quotient bit per cycle.
// Truncates toward zero; divisor is the positive sample count.
// No package dependencies.
module dse_div #(
   parameter int SUM_W = 19,
   parameter int CNT_W = 4,
   parameter int Q_W   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_W-1:0] dividend,
   input  logic        [CNT_W-1:0] divisor,
   output logic                    busy,
   output logic        [Q_W-1:0]   quotient
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              neg_ff, neg_in;
   logic [CNT_W:0]    trial;
   logic              qbit;
   logic [SUM_W-1:0]  signed_quo;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign qbit  = (trial >= {1'b0, divisor});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      if (start) begin
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_in  = '0;
         step_in = STEP_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = qbit ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], qbit};
         step_in = step_ff - STEP_W'(1);
         busy_in = (step_ff != STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
   end

   assign signed_quo = neg_ff ? (~quo_ff + SUM_W'(1)) : quo_ff;
   assign quotient   = signed_quo[Q_W-1:0];
   assign busy       = busy_ff;

endmodule

>>> src/dse_datapath.sv
// Datapath for the descriptive statistics engine: sample memory, running
// sum and extremes, rank/frequency scan, mean divider and result register.
// Depends on dse_pkg and dse_div.
module dse_datapath #(
   parameter int MAX_SAMPLES = 8,
   parameter int SAMPLE_BITS = 16,
   parameter int CNT_W       = 4,
   parameter int ADDR_W      = 3,
   parameter int SUM_W       = 19,
   parameter int RSP_W       = 72
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  dse_pkg::dse_cmd_type   cmd,
   output dse_pkg::dse_stat_type  stat,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [RSP_W-1:0]       rsp_tdata,
   output logic                   overflow
);

   localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(MAX_SAMPLES);

   logic signed [SAMPLE_BITS-1:0] mem [0:MAX_SAMPLES-1];

   logic        [CNT_W-1:0]       count_ff;
   logic signed [SUM_W-1:0]       sum_ff;
   logic signed [SAMPLE_BITS-1:0] min_ff, max_ff;
   logic                          drop_ff;
   logic        [ADDR_W-1:0]      i_ff, j_ff;
   logic signed [SAMPLE_BITS-1:0] rd_data_ff, cand_ff;
   logic                          cand_pend_ff, cmp_v_ff;
   logic        [CNT_W-1:0]       less_ff, eq_ff, best_ff;
   logic signed [SAMPLE_BITS-1:0] med_ff, mode_ff;
   logic                          rsp_valid_ff;
   logic        [SAMPLE_BITS-1:0] out_mean_ff, out_med_ff, out_mode_ff, out_spread_ff;
   logic        [CNT_W-1:0]       out_best_ff, out_count_ff;
   logic                          out_drop_ff;

   logic signed [SAMPLE_BITS-1:0] sample_s;
   logic signed [SUM_W-1:0]       sample_x;
   logic                          has_room;
   logic        [ADDR_W-1:0]      last_idx, rd_addr;
   logic        [CNT_W-1:0]       count_m1, med_rank;
   logic        [CNT_W:0]         le_count;
   logic                          med_hit, mode_hit;
   logic        [SAMPLE_BITS-1:0] mean_q;
   logic                          div_busy;

   assign sample_s = signed'(sample);
   assign sample_x = SUM_W'(sample_s);
   assign has_room = (count_ff < CAPACITY);
   assign count_m1 = count_ff - CNT_W'(1);
   assign last_idx = count_m1[ADDR_W-1:0];
   assign med_rank = count_m1 >> 1;
   assign le_count = {1'b0, less_ff} + {1'b0, eq_ff};
   assign med_hit  = (less_ff <= med_rank) && (le_count > {1'b0, med_rank});
   assign mode_hit = (eq_ff > best_ff) || ((eq_ff == best_ff) && (cand_ff > mode_ff));
   assign rd_addr  = cmd.fetch ? i_ff : j_ff;

   dse_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W),
      .Q_W   (SAMPLE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .busy     (div_busy),
      .quotient (mean_q)
   );

   // sample memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load && has_room) mem[count_ff[ADDR_W-1:0]] <= sample_s;
      rd_data_ff <= mem[rd_addr];
   end

   // set accumulation
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         drop_ff  <= 1'b0;
      end else if (cmd.publish) begin
         count_ff <= '0;
         sum_ff   <= '0;
         drop_ff  <= 1'b0;
      end else if (cmd.load) begin
         if (has_room) begin
            count_ff <= count_ff + CNT_W'(1);
            sum_ff   <= sum_ff + sample_x;
         end else begin
            drop_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && has_room) begin
         if (count_ff == '0 || sample_s < min_ff) min_ff <= sample_s;
         if (count_ff == '0 || sample_s > max_ff) max_ff <= sample_s;
      end
   end

   // rank and frequency scan
   always_ff @(posedge clock) begin
      if (reset) begin
         cand_pend_ff <= 1'b0;
         cmp_v_ff     <= 1'b0;
      end else begin
         cand_pend_ff <= cmd.fetch;
         cmp_v_ff     <= cmd.scan;
      end
      if (cand_pend_ff) cand_ff <= rd_data_ff;
      if (cmd.start) begin
         i_ff    <= '0;
         j_ff    <= '0;
         best_ff <= '0;
      end
      if (cmd.scan) j_ff <= stat.scan_last ? '0 : j_ff + ADDR_W'(1);
      if (cmd.fetch) begin
         less_ff <= '0;
         eq_ff   <= '0;
      end else if (cmp_v_ff) begin
         if (rd_data_ff < cand_ff)  less_ff <= less_ff + CNT_W'(1);
         if (rd_data_ff == cand_ff) eq_ff   <= eq_ff + CNT_W'(1);
      end
      if (cmd.eval) begin
         i_ff <= i_ff + ADDR_W'(1);
         if (med_hit) med_ff <= cand_ff;
         if (mode_hit) begin
            mode_ff <= cand_ff;
            best_ff <= eq_ff;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.publish) begin
         out_mean_ff   <= mean_q;
         out_med_ff    <= med_ff;
         out_mode_ff   <= mode_ff;
         out_best_ff   <= best_ff;
         out_spread_ff <= SAMPLE_BITS'(max_ff - min_ff);
         out_count_ff  <= count_ff;
         out_drop_ff   <= drop_ff;
      end
   end

   assign stat.scan_last = (j_ff == last_idx);
   assign stat.eval_last = (i_ff == last_idx);
   assign stat.div_busy  = div_busy;
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({out_count_ff, out_spread_ff, out_best_ff,
                               out_mode_ff, out_med_ff, out_mean_ff});
   assign overflow   = out_drop_ff;

endmodule

>>> src/descriptive_statistics_engine_core.sv
// Descriptive statistics engine, top level.
// Instantiates dse_ctrl and dse_datapath; depends on dse_pkg.
//
// Usage:
//   Samples enter on the req_ channel, one item per cycle while req_tready
//   is high. req_tdata carries the signed sample, req_tlast closes the set.
//   Up to MAX_SAMPLES samples are kept; later ones are dropped and the
//   result's overflow bit (rsp_tuser) is set.
//   After the item with req_tlast, req_tready stays low while the set is
//   ranked: every stored sample is compared against every stored sample,
//   itself included, through the single read port of the sample memory.
//   The result is published once the ranking and the bit-serial mean
//   division have both finished.
//   One rsp_ item per set: mean, lower median, mode and its count, spread,
//   sample count. The result sits in an output register; the next set can
//   load while it waits. If the receiver stalls, a finished result of the
//   following set waits until the register is freed.
//   Reset clears the sample count, sum, drop flag and result valid.
module descriptive_statistics_engine_core #(
   parameter  int MAX_SAMPLES = 8,
   parameter  int SAMPLE_BITS = 16,
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1),
   localparam int ADDR_W      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
   localparam int SUM_W       = SAMPLE_BITS + $clog2(MAX_SAMPLES),
   localparam int REQ_W       = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_BITS    = 4 * SAMPLE_BITS + 2 * CNT_W,
   localparam int RSP_W       = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // sample
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // mean, median, mode, mode_count, spread, sample_count
   output logic [0:0]       rsp_tuser   // overflow
);

   localparam int MC_LO = 3 * SAMPLE_BITS;
   localparam int SC_LO = 4 * SAMPLE_BITS + CNT_W;

   dse_pkg::dse_cmd_type  cmd;
   dse_pkg::dse_stat_type stat;

   dse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dse_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W),
      .ADDR_W      (ADDR_W),
      .SUM_W       (SUM_W),
      .RSP_W       (RSP_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .sample     (req_tdata[SAMPLE_BITS-1:0]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .overflow   (rsp_tuser[0])
   );

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.start, cmd.fetch, cmd.scan, cmd.eval, cmd.publish}))
      else $error("controller issued overlapping commands");

   a_close_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("input still open after the closing item");

   a_no_load_while_dividing: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !stat.div_busy)
      else $error("input open while the mean division runs");

   a_mode_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[MC_LO +: CNT_W] <= rsp_tdata[SC_LO +: CNT_W]) &&
                     (rsp_tdata[MC_LO +: CNT_W] != '0))
      else $error("mode count outside one to sample count");

endmodule
